/* rtl/core/heap_sort_engine_top_macros.svh */
// ----------------------------------------------------------------------------
// Heap sort engine assertion macros
// Shared assertion helpers for the heap sort engine modules.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_TOP_MACROS_SVH
`define HEAP_SORT_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define HSE_ASSERT_IMP(name, clk_s, rstn_s, pre, post, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HSE_ASSERT_NXT(name, clk_s, rstn_s, pre, post, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/core/hse_pkg.sv */
// ----------------------------------------------------------------------------
// Heap sort engine package
// Value width, command queue sizing and the command record that the front
// end hands to the sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hse_pkg;

	// Width of one sorted value.
	localparam int VALUE_W = 32;

	// Command queue between the front end and the sorter.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

	// One classified request: the value, whether it is kept, whether it
	// closes the set, and whether the set has lost values so far.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      store;
		logic                      is_last;
		logic                      ovf;
	} cmd_t;

endpackage

/* rtl/core/hse_front.sv */
// ----------------------------------------------------------------------------
// Heap sort engine front end
// Accepts input requests, tracks how many values of the current set fit in
// the buffer and marks each request as kept or dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hse_front import hse_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [VALUE_W-1:0] sample_value,
	input  logic                      is_final,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	output cmd_t                      cmd,
	output logic                      cmd_push,
	input  logic                      queue_full
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int LW = AW + 1;

	logic [LW-1:0] cnt_q;
	logic          ovf_q;
	logic          keep;

	// A value is kept while the set still has room.
	assign keep = cnt_q < LW'(MAX_ITEMS);

	assign cmd.value   = sample_value;
	assign cmd.store   = keep;
	assign cmd.is_last = is_final;
	assign cmd.ovf     = ovf_q | ~keep;

	assign sample_stall = queue_full;
	assign cmd_push     = sample_valid & ~queue_full;

	// Per-set occupancy and overflow tracking; a final request starts a new set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd_push) begin
			if (is_final) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (keep) begin
					cnt_q <= cnt_q + LW'(1);
				end
				ovf_q <= cmd.ovf;
			end
		end
	end

endmodule

/* rtl/core/hse_queue.sv */
// ----------------------------------------------------------------------------
// Heap sort engine command queue
// Small FIFO that decouples the front end from the sorter so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heap_sort_engine_top_macros.svh"

module hse_queue import hse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_cmd,
	input  logic push,
	output logic full,
	output cmd_t pop_cmd,
	output logic pop_valid,
	input  logic pop
);

	localparam int CW = QUEUE_PW + 1;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [CW-1:0]       cnt_q;

	assign full      = cnt_q == CW'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	`HSE_ASSERT_IMP(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= CW'(QUEUE_DEPTH), "queue occupancy beyond depth")
	`HSE_ASSERT_NXT(a_queue_no_pop_empty, clk, arst_n, cnt_q == '0 && !push, cnt_q == '0, "queue count moved while empty")

endmodule

/* rtl/core/hse_back.sv */
// ----------------------------------------------------------------------------
// Heap sort engine sorter
// Loads kept values into the value memory, runs a min-heap heapsort with one
// memory read and one write per cycle, then streams the values out in
// ascending order through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heap_sort_engine_top_macros.svh"

module hse_back import hse_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic                      cmd_valid,
	output logic                      cmd_pop,
	output logic signed [VALUE_W-1:0] sorted_value,
	output logic                      end_of_run,
	output logic                      overflowed,
	output logic                      result_valid,
	input  logic                      result_stall
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int LW = AW + 1;
	localparam int CW = AW + 2;

	typedef enum logic [3:0] {
		S_LOAD,
		S_NEXT,
		S_RD_PAR,
		S_PAR,
		S_RD_R,
		S_CMP,
		S_WR2,
		S_SW_R0,
		S_SW_R1,
		S_SW_W0,
		S_SW_W1,
		S_OUT_RD,
		S_OUT_LD
	} state_t;

	typedef enum logic {
		PH_BUILD,
		PH_EXTRACT
	} phase_t;

	// Value memory: one write and one registered read per cycle.
	logic signed [VALUE_W-1:0] mem [MAX_ITEMS];
	logic signed [VALUE_W-1:0] rdata_q;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;

	state_t                    state_q;
	phase_t                    phase_q;
	logic [LW-1:0]             fill_q;
	logic                      ovf_q;
	logic [LW-1:0]             len_q;
	logic [LW-1:0]             hlen_q;
	logic [LW-1:0]             k_q;
	logic [AW-1:0]             at_q;
	logic [AW-1:0]             best_idx_q;
	logic [AW-1:0]             idx_q;
	logic signed [VALUE_W-1:0] best_val_q;
	logic signed [VALUE_W-1:0] par_val_q;
	logic signed [VALUE_W-1:0] swap_q;
	logic signed [VALUE_W-1:0] sorted_value_q;
	logic                      end_of_run_q;
	logic                      overflowed_q;
	logic                      result_valid_q;

	logic                      store_ok;
	logic [LW-1:0]             len_c;
	logic [LW-1:0]             kminus1;
	logic [LW-1:0]             kminus2;
	logic [LW-1:0]             lenm1;
	logic [CW-1:0]             hlen_c;
	logic [CW-1:0]             left_c;
	logic [CW-1:0]             right_c;
	logic                      right_ok;
	logic [AW-1:0]             sel_idx;
	logic signed [VALUE_W-1:0] sel_val;
	logic                      cmp_stay;
	logic [AW-1:0]             nat_c;
	logic [CW-1:0]             nchild_c;

	assign sorted_value = sorted_value_q;
	assign end_of_run   = end_of_run_q;
	assign overflowed   = overflowed_q;
	assign result_valid = result_valid_q;

	// Load path: size of the set once the closing request is counted.
	assign store_ok = cmd.store && (fill_q < LW'(MAX_ITEMS));
	assign len_c    = fill_q + LW'(store_ok);

	assign kminus1 = k_q - LW'(1);
	assign kminus2 = k_q - LW'(2);
	assign lenm1   = len_q - LW'(1);

	// Child addresses of the node being sifted, compared against heap size.
	assign hlen_c  = {1'b0, hlen_q};
	assign left_c  = {1'b0, at_q, 1'b0} | CW'(1);
	assign right_c = {1'b0, at_q, 1'b0} + CW'(2);

	// Right child wins only if it exists and beats the current best.
	assign right_ok = (right_c < hlen_c) && (rdata_q < best_val_q);
	assign sel_idx  = right_ok ? right_c[AW-1:0] : best_idx_q;
	assign sel_val  = right_ok ? rdata_q : best_val_q;
	assign cmp_stay = !right_ok && (best_idx_q == at_q);

	// Node the sift moves to after a swap, and its left child.
	assign nat_c    = (state_q == S_WR2) ? best_idx_q : '0;
	assign nchild_c = {1'b0, nat_c, 1'b0} | CW'(1);

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		cmd_pop   = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && store_ok) begin
					mem_we    = 1'b1;
					mem_waddr = fill_q[AW-1:0];
					mem_wdata = cmd.value;
				end
			end
			S_NEXT: begin
			end
			S_RD_PAR: begin
				mem_raddr = at_q;
			end
			S_PAR: begin
				mem_raddr = left_c[AW-1:0];
			end
			S_RD_R: begin
				mem_raddr = right_c[AW-1:0];
			end
			S_CMP: begin
				if (!cmp_stay) begin
					mem_we    = 1'b1;
					mem_waddr = at_q;
					mem_wdata = sel_val;
				end
			end
			S_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = best_idx_q;
				mem_wdata = par_val_q;
				mem_raddr = nchild_c[AW-1:0];
			end
			S_SW_R0: begin
				mem_raddr = '0;
			end
			S_SW_R1: begin
				mem_raddr = kminus1[AW-1:0];
			end
			S_SW_W0: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = rdata_q;
			end
			S_SW_W1: begin
				mem_we    = 1'b1;
				mem_waddr = kminus1[AW-1:0];
				mem_wdata = swap_q;
				mem_raddr = nchild_c[AW-1:0];
			end
			S_OUT_RD: begin
				mem_raddr = idx_q;
			end
			S_OUT_LD: begin
			end
			default: begin
			end
		endcase
	end

	// Value memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Sort sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			phase_q        <= PH_BUILD;
			fill_q         <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// A new result is loaded, otherwise an accepted one is retired.
			if (state_q == S_OUT_LD) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				// Collect values until the request that closes the set.
				S_LOAD: begin
					if (cmd_valid) begin
						if (cmd.is_last) begin
							len_q   <= len_c;
							fill_q  <= '0;
							ovf_q   <= cmd.ovf;
							phase_q <= PH_BUILD;
							// One above the first build node, so S_NEXT steps onto it.
							k_q     <= (len_c >> 1) + LW'(1);
							if (len_c != '0) begin
								state_q <= S_NEXT;
							end
						end else if (store_ok) begin
							fill_q <= fill_q + LW'(1);
						end
					end
				end
				// A sift has finished: pick the next build node or extraction step.
				S_NEXT: begin
					if (phase_q == PH_BUILD) begin
						if (k_q > LW'(1)) begin
							k_q     <= kminus1;
							at_q    <= kminus2[AW-1:0];
							hlen_q  <= len_q;
							state_q <= S_RD_PAR;
						end else begin
							phase_q <= PH_EXTRACT;
							k_q     <= len_q;
							if (len_q > LW'(1)) begin
								state_q <= S_SW_R0;
							end else begin
								idx_q   <= lenm1[AW-1:0];
								state_q <= S_OUT_RD;
							end
						end
					end else begin
						if (k_q > LW'(2)) begin
							k_q     <= kminus1;
							state_q <= S_SW_R0;
						end else begin
							idx_q   <= lenm1[AW-1:0];
							state_q <= S_OUT_RD;
						end
					end
				end
				S_RD_PAR: begin
					state_q <= S_PAR;
				end
				S_PAR: begin
					par_val_q <= rdata_q;
					if (left_c < hlen_c) begin
						state_q <= S_RD_R;
					end else begin
						state_q <= S_NEXT;
					end
				end
				// Left child has arrived: compare it with the sifting value.
				S_RD_R: begin
					if (rdata_q < par_val_q) begin
						best_idx_q <= left_c[AW-1:0];
						best_val_q <= rdata_q;
					end else begin
						best_idx_q <= at_q;
						best_val_q <= par_val_q;
					end
					state_q <= S_CMP;
				end
				// Right child has arrived: stop, or move the smallest child up.
				S_CMP: begin
					if (cmp_stay) begin
						state_q <= S_NEXT;
					end else begin
						best_idx_q <= sel_idx;
						state_q    <= S_WR2;
					end
				end
				// Sifting value drops into the child's slot and the walk continues.
				S_WR2: begin
					at_q <= best_idx_q;
					if (nchild_c < hlen_c) begin
						state_q <= S_RD_R;
					end else begin
						state_q <= S_NEXT;
					end
				end
				// Swap the heap minimum with the last heap entry.
				S_SW_R0: begin
					state_q <= S_SW_R1;
				end
				S_SW_R1: begin
					swap_q  <= rdata_q;
					state_q <= S_SW_W0;
				end
				S_SW_W0: begin
					par_val_q <= rdata_q;
					hlen_q    <= kminus1;
					state_q   <= S_SW_W1;
				end
				S_SW_W1: begin
					at_q <= '0;
					if (nchild_c < hlen_c) begin
						state_q <= S_RD_R;
					end else begin
						state_q <= S_NEXT;
					end
				end
				// The memory holds descending order, so read it from the top down.
				S_OUT_RD: begin
					if (!result_valid_q || !result_stall) begin
						state_q <= S_OUT_LD;
					end
				end
				S_OUT_LD: begin
					sorted_value_q <= rdata_q;
					end_of_run_q   <= idx_q == '0;
					overflowed_q   <= ovf_q;
					if (idx_q == '0) begin
						state_q <= S_LOAD;
					end else begin
						idx_q   <= idx_q - AW'(1);
						state_q <= S_OUT_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	`HSE_ASSERT_IMP(a_sift_in_heap, clk, arst_n, state_q == S_RD_R || state_q == S_CMP, LW'(at_q) < hlen_q && hlen_q <= len_q, "sift node outside the heap")
	`HSE_ASSERT_IMP(a_out_slot_free, clk, arst_n, state_q == S_OUT_LD, !result_valid_q, "result loaded over a pending result")
	`HSE_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= LW'(MAX_ITEMS), "fill count beyond capacity")
	`HSE_ASSERT_IMP(a_no_pop_busy, clk, arst_n, state_q != S_LOAD, !cmd_pop, "request taken while sorting")

endmodule

/* rtl/core/heap_sort_engine_top.sv */
// ----------------------------------------------------------------------------
// Heap sort engine
// Collects signed 32-bit values, one per request, until a request marked
// final arrives, then emits the whole set in ascending order with the last
// result flagged. Up to MAX_ITEMS values are held per set; further values
// are dropped and every result of that set carries the overflow flag. Input
// requests are taken one per cycle, unless the queue is full, into a
// four-entry queue while the sorter runs, so the next set can start arriving
// during sorting. The sorter loads the set, sifts each build node down the
// heap, then for each extraction swaps the heap minimum with the last entry
// and sifts again, and finally unloads the results one at a time, all bounded
// by the single read and single write port of the value memory. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_sort_engine_top import hse_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [VALUE_W-1:0] sample_value,
	input  logic                      is_final,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	output logic signed [VALUE_W-1:0] sorted_value,
	output logic                      end_of_run,
	output logic                      overflowed,
	output logic                      result_valid,
	input  logic                      result_stall
);

	cmd_t front_cmd;
	logic front_push;
	logic queue_full;
	cmd_t queue_cmd;
	logic queue_valid;
	logic queue_pop;

	// Request classification.
	hse_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_value(sample_value),
		.is_final    (is_final),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.cmd         (front_cmd),
		.cmd_push    (front_push),
		.queue_full  (queue_full)
	);

	// Decoupling queue.
	hse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cmd (front_cmd),
		.push     (front_push),
		.full     (queue_full),
		.pop_cmd  (queue_cmd),
		.pop_valid(queue_valid),
		.pop      (queue_pop)
	);

	// Heapsort and result stream.
	hse_back #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (queue_cmd),
		.cmd_valid   (queue_valid),
		.cmd_pop     (queue_pop),
		.sorted_value(sorted_value),
		.end_of_run  (end_of_run),
		.overflowed  (overflowed),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
